FILE: rtl/assert_macros.svh
// Assertion macros shared by the calibrator RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dcal_pkg.sv
// Package for the oscillator code calibrator: widths, field positions and codes.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package dcal_pkg;

	// Code and counter widths.
	localparam int CODE_BITS  = 12;
	localparam int COUNT_BITS = 16;
	localparam int TRIAL_BITS = $clog2(CODE_BITS);
	localparam int SLOW_BITS  = 8;

	// Configuration register widths and port sizing.
	localparam int TARGET_BITS = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 1;

	// Output field widths.
	localparam int RANGE_BITS = 3;
	localparam int TAP_BITS   = 3;
	localparam int MOD_BITS   = 5;

	typedef logic [CODE_BITS-1:0]   code_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [TRIAL_BITS-1:0]  trial_t;
	typedef logic [SLOW_BITS-1:0]   slow_t;
	typedef logic [TARGET_BITS-1:0] target_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

	// Request command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes.
	localparam cfg_index_t CFG_TARGET_DELTA = 1'b0;
	localparam cfg_index_t CFG_WINDOW_TICKS = 1'b1;

	// Reset values of the configuration registers.
	localparam target_t TARGET_RESET = 16'd1024;
	localparam slow_t   WINDOW_RESET = 8'd8;

	// Code masks for the final tap check and modulation clear.
	localparam code_t TAP_MASK = 12'h0e0;
	localparam code_t MOD_MASK = 12'h01f;

	// First trial bit after a start.
	localparam trial_t TRIAL_TOP = TRIAL_BITS'(CODE_BITS - 1);

endpackage

FILE: rtl/dcal_req_if.sv
// Request and result channel interfaces for the oscillator code calibrator.
// Depends on dcal_pkg for the field widths.
`timescale 1ns / 1ps
interface dcal_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic fast_edge;
	logic slow_edge;

	modport source (output valid, output cmd, output fast_edge, output slow_edge,
		input ready);
	modport sink (input valid, input cmd, input fast_edge, input slow_edge,
		output ready);
endinterface

interface dcal_res_if;
	import dcal_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_select;
	logic [TAP_BITS-1:0]   tap_select;
	logic [MOD_BITS-1:0]   modulation;
	logic                  busy_res;
	logic                  done_res;

	modport source (output valid, output range_select, output tap_select,
		output modulation, output busy_res, output done_res, input ready);
	modport sink (input valid, input range_select, input tap_select,
		input modulation, input busy_res, input done_res, output ready);
endinterface

FILE: rtl/dco_successive_approx_calibrator.sv
// Successive-approximation oscillator code calibrator, top level.
// Depends on dcal_pkg, the channel interfaces in dcal_req_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Each request on req is one tick: cmd low starts a new calibration (the code
// is cleared and the trial on the top code bit begins), cmd high is one clock
// tick carrying the fast and slow edge flags. Every request yields exactly one
// result on res with the driven code split into range_select, tap_select and
// modulation, plus busy_res and done_res.
// Each trial measures two windows of window_ticks slow edges and keeps the
// trial bit when the second window's fast count is not above target_delta.
// Configuration (target_delta, window_ticks) is written through cfg_we,
// cfg_index and cfg_wdata while no request is in flight.
// A request passes the input register and then the result register. One
// request is accepted every cycle while the result register frees; the state
// update (counter increments, compare and bit set) lies between those two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; after that req.ready drops.
// Reset clears the code, the counters and both flags, reloads the
// configuration defaults and empties both registers.
module dco_successive_approx_calibrator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  dcal_pkg::cfg_index_t      cfg_index,
	input  dcal_pkg::cfg_data_t       cfg_wdata,
	dcal_req_if.sink                  req,
	dcal_res_if.source                res
);
	import dcal_pkg::*;

	// Configuration registers.
	target_t target_delta_q;
	slow_t   window_ticks_q;

	// Calibration state.
	code_t  kept_code_q;
	trial_t trial_bit_q;
	logic   second_window_q;
	slow_t  slow_count_q;
	count_t fast_count_q;
	logic   running_q;
	logic   finished_q;

	// Input stage.
	logic valid_s1;
	logic cmd_s1;
	logic fast_s1;
	logic slow_s1;

	// Result stage.
	logic res_valid_q;
	code_t res_code_q;
	logic res_busy_q;
	logic res_done_q;

	// Next-state values.
	code_t  kept_next;
	code_t  kept_trial;
	trial_t trial_next;
	logic   second_next;
	slow_t  slow_next;
	slow_t  slow_inc;
	count_t fast_next;
	count_t fast_inc;
	logic   running_next;
	logic   finished_next;
	code_t  drive_code;

	logic out_adv;
	logic step;

	// Handshake: the result register frees when empty or taken.
	assign out_adv   = !res_valid_q || res.ready;
	assign req.ready = !valid_s1 || out_adv;
	assign step      = valid_s1 && out_adv;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_delta_q <= TARGET_RESET;
			window_ticks_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_DELTA: target_delta_q <= cfg_wdata[TARGET_BITS-1:0];
				CFG_WINDOW_TICKS: window_ticks_q <= cfg_wdata[SLOW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			fast_s1 <= req.fast_edge;
			slow_s1 <= req.slow_edge;
		end
	end

	// One request of the calibration: a start clears the state; a tick counts edges, closes windows, settles trials.
	always_comb begin
		fast_inc      = fast_count_q + COUNT_BITS'(fast_s1);
		slow_inc      = slow_count_q + SLOW_BITS'(1);
		kept_trial    = kept_code_q | (code_t'(1) << trial_bit_q);
		kept_next     = kept_code_q;
		trial_next    = trial_bit_q;
		second_next   = second_window_q;
		slow_next     = slow_count_q;
		fast_next     = fast_count_q;
		running_next  = running_q;
		finished_next = finished_q;
		if (cmd_s1 == CMD_START) begin
			kept_next     = '0;
			trial_next    = TRIAL_TOP;
			second_next   = 1'b0;
			slow_next     = '0;
			fast_next     = '0;
			running_next  = 1'b1;
			finished_next = 1'b0;
		end else if (running_q) begin
			fast_next = fast_inc;
			if (slow_s1) begin
				slow_next = slow_inc;
				if (slow_inc == window_ticks_q) begin
					slow_next   = '0;
					fast_next   = '0;
					second_next = !second_window_q;
					if (second_window_q) begin
						// Second window closed: decide the trial bit.
						if (fast_inc <= target_delta_q) begin
							kept_next = kept_trial;
						end
						if (trial_bit_q == '0) begin
							if ((kept_next & TAP_MASK) == TAP_MASK) begin
								kept_next = kept_next & ~MOD_MASK;
							end
							running_next  = 1'b0;
							finished_next = 1'b1;
						end else begin
							trial_next = trial_bit_q - TRIAL_BITS'(1);
						end
					end
				end
			end
		end
		drive_code = running_next ? (kept_next | (code_t'(1) << trial_next)) : kept_next;
	end

	// State registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_code_q     <= '0;
			trial_bit_q     <= TRIAL_TOP;
			second_window_q <= 1'b0;
			slow_count_q    <= '0;
			fast_count_q    <= '0;
			running_q       <= 1'b0;
			finished_q      <= 1'b0;
		end else if (step) begin
			kept_code_q     <= kept_next;
			trial_bit_q     <= trial_next;
			second_window_q <= second_next;
			slow_count_q    <= slow_next;
			fast_count_q    <= fast_next;
			running_q       <= running_next;
			finished_q      <= finished_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_code_q <= drive_code;
			res_busy_q <= running_next;
			res_done_q <= finished_next;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.range_select = res_code_q[10:8];
	assign res.tap_select   = res_code_q[7:5];
	assign res.modulation   = res_code_q[4:0];
	assign res.busy_res     = res_busy_q;
	assign res.done_res     = res_done_q;

	// While idle, the window counters sit cleared.
	`ASSERT_IMPL(a_idle_clear, clk, arst_n, !running_q, slow_count_q == '0 && fast_count_q == '0 && !second_window_q)
	// Running and finished never hold together.
	`ASSERT_IMPL(a_busy_done, clk, arst_n, res_valid_q, !(res_busy_q && res_done_q))
	// A start puts the block on the top trial bit with an empty code.
	`ASSERT_NEXT(a_start, clk, arst_n, step && cmd_s1 == CMD_START, running_q && trial_bit_q == TRIAL_TOP && kept_code_q == '0)
	// The trial bit stays inside the code.
	`ASSERT_IMPL(a_trial_range, clk, arst_n, 1'b1, trial_bit_q <= TRIAL_TOP)

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the successive-approximation oscillator code calibrator.
// Depends on dcal_pkg and the channel interfaces in dcal_req_if.sv.
`timescale 1ns / 1ps
module testbench;
	import dcal_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 1850;
	localparam int REPORT_MAX  = 10;

	// One result as the block should present it.
	typedef struct packed {
		logic [RANGE_BITS-1:0] range_select;
		logic [TAP_BITS-1:0]   tap_select;
		logic [MOD_BITS-1:0]   modulation;
		logic                  busy_res;
		logic                  done_res;
	} cal_result_t;

	// Tracks the calibration state and holds the outputs still owed by the block.
	class code_scoreboard;
		target_t     target;
		slow_t       window;
		code_t       kept;
		trial_t      trial_pos;
		logic        second_win;
		slow_t       slow_cnt;
		count_t      fast_cnt;
		logic        running;
		logic        finished;
		cal_result_t owed_q[$];
		int          mismatches;
		int          checked;
		int          calibrations;

		function new();
			target       = TARGET_RESET;
			window       = WINDOW_RESET;
			kept         = '0;
			trial_pos    = TRIAL_TOP;
			second_win   = 1'b0;
			slow_cnt     = '0;
			fast_cnt     = '0;
			running      = 1'b0;
			finished     = 1'b0;
			mismatches   = 0;
			checked      = 0;
			calibrations = 0;
		endfunction

		function void set_config(cfg_index_t idx, cfg_data_t data);
			if (idx == CFG_TARGET_DELTA)
				target = data;
			else
				window = data[SLOW_BITS-1:0];
		endfunction

		// Applies one accepted request; returns whether it did anything.
		function bit note_request(logic cmd, logic fast, logic slow);
			bit          effective;
			code_t       drive;
			cal_result_t want;
			effective = (cmd == CMD_START) || running;
			if (cmd == CMD_START) begin
				kept       = '0;
				trial_pos  = TRIAL_TOP;
				second_win = 1'b0;
				slow_cnt   = '0;
				fast_cnt   = '0;
				running    = 1'b1;
				finished   = 1'b0;
			end else if (running) begin
				if (fast)
					fast_cnt = fast_cnt + 1'b1;
				if (slow) begin
					slow_cnt = slow_cnt + 1'b1;
					if (slow_cnt == window) begin
						if (!second_win) begin
							// First window only settles the oscillator.
							second_win = 1'b1;
						end else begin
							// Second window decides the trial bit.
							if (fast_cnt <= target)
								kept = kept | (code_t'(1) << trial_pos);
							if (trial_pos == '0) begin
								if ((kept & TAP_MASK) == TAP_MASK)
									kept = kept & ~MOD_MASK;
								running  = 1'b0;
								finished = 1'b1;
								calibrations++;
							end else begin
								trial_pos = trial_pos - 1'b1;
							end
							second_win = 1'b0;
						end
						slow_cnt = '0;
						fast_cnt = '0;
					end
				end
			end
			drive = kept;
			if (running)
				drive = drive | (code_t'(1) << trial_pos);
			want.range_select = drive[10:8];
			want.tap_select   = drive[7:5];
			want.modulation   = drive[4:0];
			want.busy_res     = running;
			want.done_res     = finished;
			owed_q.push_back(want);
			return effective;
		endfunction

		// Compares one accepted result with the oldest owed one.
		function void check_result(cal_result_t got);
			cal_result_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result at %0t: range %0d tap %0d mod %0d busy %b done %b",
						$realtime, got.range_select, got.tap_select, got.modulation,
						got.busy_res, got.done_res);
				return;
			end
			want = owed_q.pop_front();
			checked++;
			if (got.range_select !== want.range_select || got.tap_select !== want.tap_select ||
					got.modulation !== want.modulation || got.busy_res !== want.busy_res ||
					got.done_res !== want.done_res) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch at %0t: want %0d/%0d/%0d busy %b done %b, got %0d/%0d/%0d busy %b done %b",
						$realtime, want.range_select, want.tap_select, want.modulation,
						want.busy_res, want.done_res, got.range_select, got.tap_select,
						got.modulation, got.busy_res, got.done_res);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_wdata;

	dcal_req_if req_ch ();
	dcal_res_if res_ch ();

	dco_successive_approx_calibrator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	code_scoreboard sb;

	// Sender burst shaping and receiver stall pattern.
	bit       gaps_on;
	int       burst_left;
	logic [7:0] stall_mask;
	int       stall_pos;
	int       hold_left;
	bit       long_hold_req;
	int       long_holds;

	int cycle_cnt;
	int total_reqs;
	int live_reqs;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result receiver: checks accepted results and stalls on its own pattern.
	initial begin
		hold_left = 0;
		stall_pos = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				sb.check_result({res_ch.range_select, res_ch.tap_select, res_ch.modulation,
					res_ch.busy_res, res_ch.done_res});
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_holds++;
				hold_left = 80;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= stall_mask[stall_pos % 8];
				stall_pos++;
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted.
	task automatic issue_request(logic cmd, logic fast, logic slow);
		if (gaps_on) begin
			if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= cmd;
		req_ch.fast_edge <= fast;
		req_ch.slow_edge <= slow;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		total_reqs++;
		if (sb.note_request(cmd, fast, slow))
			live_reqs++;
	endtask

	// Random tick with the given edge densities in percent.
	task automatic random_tick(int fast_pct, int slow_pct);
		issue_request(CMD_TICK, $urandom_range(0, 99) < fast_pct,
			$urandom_range(0, 99) < slow_pct);
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers; the window word carries random upper bits.
	task automatic write_settings(target_t tgt, slow_t win);
		cfg_data_t win_word;
		win_word = {8'($urandom_range(0, 255)), win};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TARGET_DELTA;
		cfg_wdata <= tgt;
		sb.set_config(CFG_TARGET_DELTA, tgt);
		@(posedge clk);
		cfg_index <= CFG_WINDOW_TICKS;
		cfg_wdata <= win_word;
		sb.set_config(CFG_WINDOW_TICKS, win_word);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stimulus.
	initial begin
		int      phase_no;
		int      win;
		int      fast_pct;
		int      slow_pct;
		int      cut;
		int      n;
		bit      broken;
		target_t tgt;

		sb               = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_TARGET_DELTA;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_TICK;
		req_ch.fast_edge = 1'b0;
		req_ch.slow_edge = 1'b0;
		res_ch.ready     = 1'b0;
		stall_mask       = 8'hff;
		gaps_on          = 1'b0;
		burst_left       = 0;
		long_hold_req    = 1'b0;
		long_holds       = 0;
		cycle_cnt        = 0;
		total_reqs       = 0;
		live_reqs        = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ticks before any start leave the outputs at reset.
		issue_request(CMD_TICK, 1'b1, 1'b1);
		issue_request(CMD_TICK, 1'b0, 1'b0);
		wait_quiet();

		// Largest target, one-edge windows: a restart mid-trial, then every tick
		// closes a window with a fast edge in the same tick, so every bit is kept
		// and the final tap check clears the modulation bits.
		write_settings(16'hffff, 8'd1);
		issue_request(CMD_START, 1'b0, 1'b1);
		repeat (3) issue_request(CMD_TICK, 1'b1, 1'b1);
		issue_request(CMD_START, 1'b1, 1'b1);
		repeat (24) issue_request(CMD_TICK, 1'b1, 1'b1);
		issue_request(CMD_TICK, 1'b1, 1'b1);
		wait_quiet();

		// A zero window length means 256 slow edges per window.
		gaps_on = 1'b1;
		stall_mask = 8'($urandom_range(1, 255));
		write_settings(target_t'($urandom_range(64, 192)), 8'd0);
		issue_request(CMD_START, 1'b0, 1'b0);
		repeat (520) random_tick(50, 100);
		wait_quiet();

		// Window of 255 slow edges, the longest nonzero setting.
		write_settings(target_t'($urandom_range(100, 155)), 8'd255);
		issue_request(CMD_START, 1'b0, 1'b0);
		repeat (520) random_tick(50, 100);
		wait_quiet();

		// Random calibrations, mostly run to completion with random edge traffic.
		phase_no  = 0;
		while (total_reqs < ITEM_TARGET) begin
			gaps_on    = ($urandom_range(0, 3) != 0);
			stall_mask = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
			win        = $urandom_range(1, 4);
			fast_pct   = $urandom_range(0, 100);
			slow_pct   = $urandom_range(25, 100);
			case ($urandom_range(0, 7))
				0:       tgt = '0;
				1:       tgt = 16'hffff;
				2:       tgt = target_t'($urandom_range(0, 65535));
				default: tgt = target_t'($urandom_range(0, 4 * win));
			endcase
			broken = (phase_no != 0) && ($urandom_range(0, 5) == 0);
			cut    = $urandom_range(1, 30);
			write_settings(tgt, slow_t'(win));

			// Long receiver hold while requests keep coming.
			if (!broken && (phase_no % 8 == 0))
				long_hold_req = 1'b1;

			issue_request(CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			n = 0;
			while (sb.running && !(broken && n >= cut)) begin
				if ($urandom_range(0, 149) == 0)
					issue_request(CMD_START, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					random_tick(fast_pct, slow_pct);
				n++;
			end
			repeat ($urandom_range(0, 2)) random_tick(50, 50);
			wait_quiet();
			phase_no++;
		end

		$display("Ran %0d requests (%0d changed state), %0d calibrations finished, %0d checked.",
			total_reqs, live_reqs, sb.calibrations, sb.checked);
		$display("Windows of 0, 1 to 4 and 255 slow edges, restarts, %0d long holds.",
			long_holds);
		if (sb.mismatches == 0 && sb.owed_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
